>>> hdl/utcp_pkg.sv
// Shared types and constants for the UTC offset string parser.
`default_nettype none

package utcp_pkg;

  localparam int MAX_LEN   = 15;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 7;
  localparam int OFFSET_W  = 17;
  localparam int STATUS_W  = 3;
  localparam int TOTAL_W   = 19;

  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [POS_W-1:0] POS_NAME  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_MIN   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [VAL_W-1:0] MAX_MIN_SEC = VAL_W'(59);
  localparam logic [VAL_W-1:0] LIMIT_NEG   = VAL_W'(12);
  localparam logic [VAL_W-1:0] LIMIT_POS   = VAL_W'(14);
  localparam logic [VAL_W-1:0] TEN         = VAL_W'(10);
  localparam logic [TOTAL_W-1:0] SEC_PER_HOUR = TOTAL_W'(3600);
  localparam logic [TOTAL_W-1:0] SEC_PER_MIN  = TOTAL_W'(60);

  typedef enum logic [3:0] {
    PH_SIGN_OR_HOUR = 4'd0,
    PH_HOUR_FIRST   = 4'd1,
    PH_HOUR_SECOND  = 4'd2,
    PH_AFTER_HOUR   = 4'd3,
    PH_MIN_FIRST    = 4'd4,
    PH_MIN_SECOND   = 4'd5,
    PH_AFTER_MIN    = 4'd6,
    PH_SEC_FIRST    = 4'd7,
    PH_SEC_SECOND   = 4'd8,
    PH_DONE         = 4'd9
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_LONG   = 3'd2,
    ST_FORMAT = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             len_over;
    phase_t           phase;
    logic             negative;
    logic [VAL_W-1:0] hour;
    logic [VAL_W-1:0] minute;
    logic [VAL_W-1:0] second;
    logic             fmt_err;
  } parse_state_t;

  typedef struct packed {
    status_t                     status;
    logic signed [OFFSET_W-1:0]  offset_seconds;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/utcp_parser.sv
// Per-byte parse state, end-of-string checks and the stored offset.
`default_nettype none

module utcp_parser
  import utcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       consume,
  input  wire logic [7:0] char_byte,
  input  wire logic       last_byte,
  output result_t         result
);

  localparam parse_state_t STATE_RESET = '{
    pos: '0, len_over: 1'b0, phase: PH_SIGN_OR_HOUR, negative: 1'b0,
    hour: '0, minute: '0, second: '0, fmt_err: 1'b0};

  parse_state_t st;
  parse_state_t st_next;
  logic signed [OFFSET_W-1:0] stored_offset;

  logic             is_digit;
  logic             is_colon;
  logic [VAL_W-1:0] digit;
  logic [VAL_W-1:0] limit;
  logic [TOTAL_W-1:0] total;
  logic signed [OFFSET_W-1:0] new_offset;
  status_t          status;

  always_comb begin
    is_digit = (char_byte inside {[CH_ZERO:CH_NINE]});
    is_colon = (char_byte == CH_COLON);
    digit    = is_digit ? VAL_W'(char_byte - CH_ZERO) : '0;
  end

  // Advance the phase machine by one byte.
  always_comb begin
    st_next = st;
    if (st.pos >= POS_LIMIT) begin
      st_next.len_over = 1'b1;
    end
    if (st.pos >= POS_NAME) begin
      case (st.phase)
        PH_SIGN_OR_HOUR: begin
          if (char_byte == CH_PLUS) begin
            st_next.phase = PH_HOUR_FIRST;
          end else if (char_byte == CH_MINUS) begin
            st_next.negative = 1'b1;
            st_next.phase    = PH_HOUR_FIRST;
          end else if (is_digit) begin
            st_next.hour  = digit;
            st_next.phase = PH_HOUR_SECOND;
          end else begin
            st_next.fmt_err = 1'b1;
            st_next.phase   = PH_DONE;
          end
        end
        PH_HOUR_FIRST: begin
          if (is_digit) begin
            st_next.hour  = digit;
            st_next.phase = PH_HOUR_SECOND;
          end else begin
            st_next.fmt_err = 1'b1;
            st_next.phase   = PH_DONE;
          end
        end
        PH_HOUR_SECOND: begin
          if (is_digit) begin
            st_next.hour  = VAL_W'(st.hour * TEN) + digit;
            st_next.phase = PH_AFTER_HOUR;
          end else if (is_colon) begin
            st_next.phase = PH_MIN_FIRST;
          end else begin
            st_next.phase = PH_DONE;
          end
        end
        PH_AFTER_HOUR: begin
          st_next.phase = is_colon ? PH_MIN_FIRST : PH_DONE;
        end
        PH_MIN_FIRST: begin
          if (is_digit) begin
            st_next.minute = digit;
            st_next.phase  = PH_MIN_SECOND;
          end else begin
            st_next.fmt_err = 1'b1;
            st_next.phase   = PH_DONE;
          end
        end
        PH_MIN_SECOND: begin
          if (is_digit) begin
            st_next.minute = VAL_W'(st.minute * TEN) + digit;
            st_next.phase  = PH_AFTER_MIN;
          end else if (is_colon) begin
            st_next.phase = PH_SEC_FIRST;
          end else begin
            st_next.phase = PH_DONE;
          end
        end
        PH_AFTER_MIN: begin
          st_next.phase = is_colon ? PH_SEC_FIRST : PH_DONE;
        end
        PH_SEC_FIRST: begin
          if (is_digit) begin
            st_next.second = digit;
            st_next.phase  = PH_SEC_SECOND;
          end else begin
            st_next.fmt_err = 1'b1;
            st_next.phase   = PH_DONE;
          end
        end
        PH_SEC_SECOND: begin
          if (is_digit) begin
            st_next.second = VAL_W'(st.second * TEN) + digit;
          end
          st_next.phase = PH_DONE;
        end
        default: begin
          st_next.phase = PH_DONE;
        end
      endcase
    end
    if (st.pos != POS_MAX) begin
      st_next.pos = st.pos + POS_W'(1);
    end
  end

  // Judge the string as it stands after this byte.
  always_comb begin
    limit = st_next.negative ? LIMIT_NEG : LIMIT_POS;
    total = TOTAL_W'(st_next.hour) * SEC_PER_HOUR
          + TOTAL_W'(st_next.minute) * SEC_PER_MIN
          + TOTAL_W'(st_next.second);
    new_offset = st_next.negative ? -$signed(total[OFFSET_W-1:0])
                                  : $signed(total[OFFSET_W-1:0]);
    if (st_next.pos < POS_MIN) begin
      status = ST_SHORT;
    end else if (st_next.len_over) begin
      status = ST_LONG;
    end else if (st_next.fmt_err || st_next.phase == PH_SIGN_OR_HOUR ||
                 st_next.phase == PH_HOUR_FIRST || st_next.phase == PH_MIN_FIRST ||
                 st_next.phase == PH_SEC_FIRST) begin
      status = ST_FORMAT;
    end else if (st_next.minute > MAX_MIN_SEC || st_next.second > MAX_MIN_SEC) begin
      status = ST_RANGE;
    end else if (st_next.hour > limit) begin
      status = ST_RANGE;
    end else if (st_next.hour == limit &&
                 (st_next.minute != '0 || st_next.second != '0)) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
    result.status         = status;
    result.offset_seconds = (status == ST_OK) ? new_offset : stored_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= STATE_RESET;
      stored_offset <= '0;
    end else if (consume) begin
      if (last_byte) begin
        st <= STATE_RESET;
        if (status == ST_OK) begin
          stored_offset <= new_offset;
        end
      end else begin
        st <= st_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/utc_offset_string_parser.sv
// UTC offset string parser: top level with input and result registers.
//
// Feed a time-zone string one byte per beat, tlast on its final byte; one
// result beat follows each final byte with the status and the stored offset
// in seconds. The block takes one byte per cycle unless stalled: each beat goes
// into an input register, the parse state advances from it, and a final byte
// loads the result register from the input register. Input stalls only while
// a final byte waits for a result register that is still full. Bytes 0 to 2
// are skipped; strings shorter than 4 bytes or longer than MAX_LEN bytes
// report an error and leave the stored offset as it was.
`default_nettype none

module utc_offset_string_parser
  import utcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [2:0] status, [19:3] offset_seconds, zero above
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_free;
  logic       consume;
  result_t    result;
  result_t    out_result;

  assign out_free = !m_tvalid || m_tready;
  assign consume  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || consume;

  utcp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .consume   (consume),
    .char_byte (in_byte),
    .last_byte (in_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Hold the result beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {4'b0000, out_result.offset_seconds, out_result.status};

endmodule

`default_nettype wire
